### sv/scfc_pkg.sv
// Package: shared types, constants and helper functions for the sensor frame checker.
`default_nettype none

package scfc_pkg;

  localparam logic [7:0] CRC_INIT = 8'hFF;
  localparam logic [7:0] CRC_POLY = 8'h31;

  // byte positions within a six-byte response
  localparam logic [2:0] POS_W0_HI = 3'd0;
  localparam logic [2:0] POS_W0_LO = 3'd1;
  localparam logic [2:0] POS_CRC0  = 3'd2;
  localparam logic [2:0] POS_W1_HI = 3'd3;
  localparam logic [2:0] POS_W1_LO = 3'd4;
  localparam logic [2:0] POS_CRC1  = 3'd5;

  localparam int unsigned PROD_W = 31;

  localparam logic [PROD_W-1:0] TEMP_GAIN = 31'd17500;
  localparam logic [PROD_W-1:0] HUM_GAIN  = 31'd12500;
  localparam logic [14:0]       TEMP_OFFSET = 15'd4500;
  localparam logic [14:0]       HUM_OFFSET  = 15'd600;
  localparam logic [16:0]       DIV_K       = 17'd65535;

  typedef struct packed {
    logic        bad;
    logic [15:0] w0;
    logic [15:0] w1;
  } frame_t;

  // CRC-8, MSB first, one byte
  function automatic logic [7:0] crc8_update(logic [7:0] crc, logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
    end
    return c;
  endfunction

  // floor(x / 65535) for x < 32768*65535: x = q*65536 + l = q*65535 + (q + l)
  function automatic logic [14:0] div_65535(logic [PROD_W-1:0] x);
    logic [14:0] q;
    logic [16:0] r;
    q = x[30:16];
    r = {1'b0, x[15:0]} + {2'b00, q};
    return q + {14'd0, (r >= DIV_K)};
  endfunction

endpackage

`default_nettype wire

### sv/scfc_frame.sv
// Frame assembler: byte position, per-word CRC check and word capture.
`default_nettype none

module scfc_frame (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire logic [7:0]      rx_byte_i,
  input  wire logic            frame_start_i,
  output logic                 frm_valid_o,
  input  wire logic            frm_ready_i,
  output scfc_pkg::frame_t     frm_o
);
  import scfc_pkg::*;

  logic [2:0]  pos_q, pos_d, pos;
  logic [7:0]  crc_q, crc_d, crc_base;
  logic [15:0] w0_q, w0_d, w1_q, w1_d;
  logic        good_q, good_d;
  logic        frm_valid_q, frm_valid_d;
  frame_t      frm_q, frm_d;
  logic        in_fire, resync, push;

  assign in_ready_o = !frm_valid_q || frm_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;
  assign resync     = frame_start_i || (pos_q > POS_CRC1);
  assign pos        = resync ? POS_W0_HI : pos_q;
  assign crc_base   = resync ? CRC_INIT : crc_q;
  assign push       = in_fire && (pos == POS_CRC1);

  always_comb begin
    crc_d  = crc_q;
    w0_d   = w0_q;
    w1_d   = w1_q;
    good_d = good_q;
    pos_d  = pos_q;
    if (in_fire) begin
      pos_d = (pos == POS_CRC1) ? POS_W0_HI : pos + 3'd1;
      unique case (pos)
        POS_W0_HI: begin
          crc_d = crc8_update(CRC_INIT, rx_byte_i);
          w0_d  = {rx_byte_i, w0_q[7:0]};
        end
        POS_W0_LO: begin
          crc_d = crc8_update(crc_base, rx_byte_i);
          w0_d  = {w0_q[15:8], rx_byte_i};
        end
        POS_CRC0: begin
          good_d = (crc_base == rx_byte_i);
          crc_d  = CRC_INIT;
        end
        POS_W1_HI: begin
          crc_d = crc8_update(CRC_INIT, rx_byte_i);
          w1_d  = {rx_byte_i, w1_q[7:0]};
        end
        POS_W1_LO: begin
          crc_d = crc8_update(crc_base, rx_byte_i);
          w1_d  = {w1_q[15:8], rx_byte_i};
        end
        default: begin
          crc_d = CRC_INIT;
        end
      endcase
    end
  end

  always_comb begin
    frm_valid_d = frm_valid_q;
    frm_d       = frm_q;
    if (frm_ready_i) begin
      frm_valid_d = 1'b0;
    end
    if (push) begin
      frm_valid_d = 1'b1;
      frm_d.bad   = !(good_q && (crc_base == rx_byte_i));
      frm_d.w0    = w0_q;
      frm_d.w1    = w1_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= POS_W0_HI;
      crc_q       <= CRC_INIT;
      good_q      <= 1'b0;
      frm_valid_q <= 1'b0;
    end else begin
      pos_q       <= pos_d;
      crc_q       <= crc_d;
      good_q      <= good_d;
      frm_valid_q <= frm_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    w0_q  <= w0_d;
    w1_q  <= w1_d;
    frm_q <= frm_d;
  end

  assign frm_valid_o = frm_valid_q;
  assign frm_o       = frm_q;

endmodule

`default_nettype wire

### sv/scfc_scale.sv
// Scaling pipe: constant multiply stage, then divide-by-65535 and offset into the result register.
`default_nettype none

module scfc_scale (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              frm_valid_i,
  output logic                   frm_ready_o,
  input  wire scfc_pkg::frame_t  frm_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic                   crc_status_o,
  output logic [15:0]            first_word_o,
  output logic [15:0]            second_word_o,
  output logic [31:0]            serial_number_o,
  output logic signed [14:0]     temperature_centi_o,
  output logic signed [14:0]     humidity_centi_o
);
  import scfc_pkg::*;

  logic              p_valid_q;
  frame_t            p_frm_q;
  logic [PROD_W-1:0] t_prod_q, h_prod_q;
  logic              p_ready, p_fire, o_fire;

  logic              o_valid_q;
  frame_t            o_frm_q;
  logic [14:0]       t_q, h_q;

  assign p_ready     = !o_valid_q || out_ready_i;
  assign frm_ready_o = !p_valid_q || p_ready;
  assign p_fire      = frm_valid_i && frm_ready_o;
  assign o_fire      = p_valid_q && p_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_valid_q <= 1'b0;
      o_valid_q <= 1'b0;
    end else begin
      if (frm_ready_o) begin
        p_valid_q <= frm_valid_i;
      end
      if (p_ready) begin
        o_valid_q <= p_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (p_fire) begin
      p_frm_q  <= frm_i;
      t_prod_q <= PROD_W'(frm_i.w0) * TEMP_GAIN;
      h_prod_q <= PROD_W'(frm_i.w1) * HUM_GAIN;
    end
    if (o_fire) begin
      o_frm_q <= p_frm_q;
      t_q     <= div_65535(t_prod_q) - TEMP_OFFSET;
      h_q     <= div_65535(h_prod_q) - HUM_OFFSET;
    end
  end

  assign out_valid_o         = o_valid_q;
  assign crc_status_o        = o_frm_q.bad;
  assign first_word_o        = o_frm_q.w0;
  assign second_word_o       = o_frm_q.w1;
  assign serial_number_o     = {o_frm_q.w0, o_frm_q.w1};
  assign temperature_centi_o = $signed(t_q);
  assign humidity_centi_o    = $signed(h_q);

endmodule

`default_nettype wire

### sv/sensor_frame_crc_check_and_scale.sv
// Top level: sensor response CRC check and fixed-point scaling.
//
//   channel | direction | handshake              | payload
//   in      | input     | in_valid_i/in_ready_o  | rx_byte_i, frame_start_i
//   out     | output    | out_valid_o/out_ready_i| crc_status_o, first_word_o,
//           |           |                        | second_word_o, serial_number_o,
//           |           |                        | temperature_centi_o, humidity_centi_o
//
// One byte accepted per cycle while in_ready_o is high. From its sixth byte, a result
// passes through the frame register, the multiply register and the result register.
// Reset clears all valids, sets the byte position to 0 and the CRC to 0xFF.
// A stalled result holds; bytes keep flowing until all three stages are full.
`default_nettype none

module sensor_frame_crc_check_and_scale (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire logic [7:0]    rx_byte_i,
  input  wire logic          frame_start_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output logic               crc_status_o,
  output logic [15:0]        first_word_o,
  output logic [15:0]        second_word_o,
  output logic [31:0]        serial_number_o,
  output logic signed [14:0] temperature_centi_o,
  output logic signed [14:0] humidity_centi_o
);
  import scfc_pkg::*;

  logic   frm_valid, frm_ready;
  frame_t frm;

  scfc_frame u_frame (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .rx_byte_i    (rx_byte_i),
    .frame_start_i(frame_start_i),
    .frm_valid_o  (frm_valid),
    .frm_ready_i  (frm_ready),
    .frm_o        (frm)
  );

  scfc_scale u_scale (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .frm_valid_i        (frm_valid),
    .frm_ready_o        (frm_ready),
    .frm_i              (frm),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .crc_status_o       (crc_status_o),
    .first_word_o       (first_word_o),
    .second_word_o      (second_word_o),
    .serial_number_o    (serial_number_o),
    .temperature_centi_o(temperature_centi_o),
    .humidity_centi_o   (humidity_centi_o)
  );

endmodule

`default_nettype wire

### sv/scfc_checker.sv
// Checker on the top-level ports, bound to the top level.
`default_nettype none

module scfc_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               out_valid_o,
  input wire logic               out_ready_i,
  input wire logic               crc_status_o,
  input wire logic [15:0]        first_word_o,
  input wire logic [15:0]        second_word_o,
  input wire logic [31:0]        serial_number_o,
  input wire logic signed [14:0] temperature_centi_o,
  input wire logic signed [14:0] humidity_centi_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(serial_number_o)
      && $stable(crc_status_o) && $stable(temperature_centi_o)
      && $stable(humidity_centi_o))
    else $error("result changed while stalled");

  a_serial: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> serial_number_o[31:16] == first_word_o
      && serial_number_o[15:0] == second_word_o)
    else $error("serial number does not match words");

  a_temp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> temperature_centi_o >= -15'sd4500
      && temperature_centi_o <= 15'sd13000)
    else $error("temperature out of range");

  a_hum_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> humidity_centi_o >= -15'sd600 && humidity_centi_o <= 15'sd11900)
    else $error("humidity out of range");

endmodule

bind sensor_frame_crc_check_and_scale scfc_checker u_scfc_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .out_valid_o        (out_valid_o),
  .out_ready_i        (out_ready_i),
  .crc_status_o       (crc_status_o),
  .first_word_o       (first_word_o),
  .second_word_o      (second_word_o),
  .serial_number_o    (serial_number_o),
  .temperature_centi_o(temperature_centi_o),
  .humidity_centi_o   (humidity_centi_o)
);

`default_nettype wire
